[rtl/npst_pkg.sv]
// ============================================================================
// npst_pkg: shared types and constants for the nearest position spanning tree
// Holds the default sizes, the fixed field widths of the channels, the
// configuration register map and the command and status bundles.
// ============================================================================
package npst_pkg;

    // Default sizes handed to the top level parameters.
    localparam int NPST_MAX_SCANS  = 32;
    localparam int NPST_COORD_BITS = 24;

    // Fixed widths of the channel fields.
    localparam int NPST_POS_W  = 24;
    localparam int NPST_EIDX_W = 5;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_USE_SCAN_ORDER = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pos_we;       // store the accepted position
        logic build_init;   // clear attached set, attach position zero
        logic src_cap;      // capture the source position read last cycle
        logic sweep_start;  // reset the running minimum
        logic sweep_valid;  // one candidate enters the relax pipeline
        logic first_sweep;  // stored best values are treated as unset
        logic attach;       // mark the selected candidate as attached
        logic emit;         // load the edge output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;    // relax pipeline still holds candidates
        logic out_free;     // edge output register can take an item
    } t_sts;

endpackage

[rtl/npst_in_if.sv]
// ============================================================================
// npst_in_if: position channel
// Carries one 3D position per item, with the flag that closes the set.
// ============================================================================
interface npst_in_if import npst_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [NPST_POS_W-1:0] pos_x;
    logic signed [NPST_POS_W-1:0] pos_y;
    logic signed [NPST_POS_W-1:0] pos_z;
    logic                         last;

    modport source (output valid, pos_x, pos_y, pos_z, last, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last, output ready);

endinterface

[rtl/npst_out_if.sv]
// ============================================================================
// npst_out_if: edge channel
// Carries one spanning tree edge per item, with the flag on the final edge.
// ============================================================================
interface npst_out_if import npst_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [NPST_EIDX_W-1:0] parent_index;
    logic [NPST_EIDX_W-1:0] child_index;
    logic                   last_edge;

    modport source (output valid, parent_index, child_index, last_edge, input ready);
    modport sink   (input valid, parent_index, child_index, last_edge, output ready);

endinterface

[rtl/npst_datapath.sv]
// ============================================================================
// npst_datapath: position store, relax pipeline and edge output register
// Holds the position memory and the per position best distance memory, runs
// one candidate per cycle through distance, relax and minimum stages, and
// registers the outgoing edge.
// ============================================================================
module npst_datapath import npst_pkg::*; #(
    parameter  int MAX_SCANS  = NPST_MAX_SCANS,
    parameter  int COORD_BITS = NPST_COORD_BITS,
    localparam int IDX_W      = $clog2(MAX_SCANS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic [IDX_W-1:0]             i_rd_addr,
    input  logic [IDX_W-1:0]             i_wr_addr,
    input  logic [IDX_W-1:0]             i_src_idx,
    input  logic signed [NPST_POS_W-1:0] i_pos_x,
    input  logic signed [NPST_POS_W-1:0] i_pos_y,
    input  logic signed [NPST_POS_W-1:0] i_pos_z,
    input  logic [IDX_W-1:0]             i_e_parent,
    input  logic [IDX_W-1:0]             i_e_child,
    input  logic                         i_e_last,
    output logic [IDX_W-1:0]             o_min_idx,
    output logic [IDX_W-1:0]             o_min_parent,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [NPST_EIDX_W-1:0]       o_parent_index,
    output logic [NPST_EIDX_W-1:0]       o_child_index,
    output logic                         o_last_edge
);

    localparam int CB     = COORD_BITS;
    localparam int POS_W  = 3 * CB;
    localparam int SQ_W   = 2 * CB;
    localparam int DIST_W = 2 * CB + 2;
    localparam int NODE_W = DIST_W + IDX_W;
    localparam int EXT_W  = 32;

    typedef logic [CB-1:0] t_coord;

    // Memories and registered read data.
    logic [POS_W-1:0]  r_pos_mem  [MAX_SCANS];
    logic [NODE_W-1:0] r_node_mem [MAX_SCANS];
    logic [POS_W-1:0]  r_pos_rd;
    logic [NODE_W-1:0] r_node_rd;

    logic [MAX_SCANS-1:0] r_attached;
    logic [POS_W-1:0]     r_src;

    // Pipeline registers.
    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic [IDX_W-1:0]  r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx, r_s5_idx;
    logic [NODE_W-1:0] r_s2_node, r_s3_node, r_s4_node;
    t_coord            r_s2_mag [3];
    logic [SQ_W-1:0]   r_s3_sq  [3];
    logic [DIST_W-1:0] r_s4_dist;
    logic [DIST_W-1:0] r_s5_dist;
    logic [IDX_W-1:0]  r_s5_par;

    // Running minimum over one sweep.
    logic              r_found;
    logic [DIST_W-1:0] r_min_dist;
    logic [IDX_W-1:0]  r_min_par;
    logic [IDX_W-1:0]  r_min_idx;

    // Output register.
    logic                   r_out_valid;
    logic [NPST_EIDX_W-1:0] r_out_parent;
    logic [NPST_EIDX_W-1:0] r_out_child;
    logic                   r_out_last;

    t_coord             w_in_x, w_in_y, w_in_z;
    logic signed [CB:0] w_diff [3];
    logic signed [CB:0] w_neg  [3];
    t_coord             w_mag  [3];
    logic [SQ_W-1:0]    w_sq   [3];
    logic [DIST_W-1:0]  w_old_dist;
    logic [IDX_W-1:0]   w_old_par;
    logic               w_better;
    logic [DIST_W-1:0]  w_new_dist;
    logic [IDX_W-1:0]   w_new_par;
    logic               w_take;

    // Input coordinates keep their low COORD_BITS bits.
    assign w_in_x = CB'({{(EXT_W-NPST_POS_W){1'b0}}, i_pos_x});
    assign w_in_y = CB'({{(EXT_W-NPST_POS_W){1'b0}}, i_pos_y});
    assign w_in_z = CB'({{(EXT_W-NPST_POS_W){1'b0}}, i_pos_z});

    // Position memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_we) begin
            r_pos_mem[i_wr_addr] <= {w_in_z, w_in_y, w_in_x};
        end
        r_pos_rd <= r_pos_mem[i_rd_addr];
    end

    // Best distance and parent memory, written back by the relax stage.
    always_ff @(posedge i_clk) begin
        if (r_s4_valid && w_better) begin
            r_node_mem[r_s4_idx] <= {w_new_dist, w_new_par};
        end
        r_node_rd <= r_node_mem[i_rd_addr];
    end

    // Source position of the current relax sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.src_cap) begin
            r_src <= r_pos_rd;
        end
    end

    // Attached set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached <= '0;
        end else if (i_cmd.build_init) begin
            r_attached <= {{(MAX_SCANS-1){1'b0}}, 1'b1};
        end else if (i_cmd.attach) begin
            r_attached[r_min_idx] <= 1'b1;
        end
    end

    // Per axis absolute difference between source and candidate, and its square.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = $signed({r_src[k*CB+CB-1], r_src[k*CB +: CB]})
                      - $signed({r_pos_rd[k*CB+CB-1], r_pos_rd[k*CB +: CB]});
            w_neg[k]  = -w_diff[k];
            w_mag[k]  = w_diff[k][CB] ? w_neg[k][CB-1:0] : w_diff[k][CB-1:0];
            w_sq[k]   = SQ_W'(r_s2_mag[k]) * SQ_W'(r_s2_mag[k]);
        end
    end

    // Relax: a shorter distance wins, on a tie the smaller parent index.
    always_comb begin
        w_old_dist = i_cmd.first_sweep ? '1 : r_s4_node[NODE_W-1:IDX_W];
        w_old_par  = i_cmd.first_sweep ? '0 : r_s4_node[IDX_W-1:0];
        w_better   = (r_s4_dist < w_old_dist)
                   || ((r_s4_dist == w_old_dist) && (i_src_idx < w_old_par));
        w_new_dist = w_better ? r_s4_dist : w_old_dist;
        w_new_par  = w_better ? i_src_idx : w_old_par;
    end

    // Selection: strict improvement only, so the smaller index wins a full tie.
    assign w_take = r_s5_valid
                 && (!r_found || (r_s5_dist < r_min_dist)
                     || ((r_s5_dist == r_min_dist) && (r_s5_par < r_min_par)));

    // Pipeline valid flags and running minimum state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.sweep_valid && !r_attached[i_rd_addr];
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            if (i_cmd.sweep_start) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_rd_addr;
        r_s2_idx  <= r_s1_idx;
        r_s2_node <= r_node_rd;
        for (int k = 0; k < 3; k++) begin
            r_s2_mag[k] <= w_mag[k];
            r_s3_sq[k]  <= w_sq[k];
        end
        r_s3_idx   <= r_s2_idx;
        r_s3_node  <= r_s2_node;
        r_s4_dist  <= DIST_W'(r_s3_sq[0]) + DIST_W'(r_s3_sq[1]) + DIST_W'(r_s3_sq[2]);
        r_s4_idx   <= r_s3_idx;
        r_s4_node  <= r_s3_node;
        r_s5_dist  <= w_new_dist;
        r_s5_par   <= w_new_par;
        r_s5_idx   <= r_s4_idx;
        if (w_take) begin
            r_min_dist <= r_s5_dist;
            r_min_par  <= r_s5_par;
            r_min_idx  <= r_s5_idx;
        end
    end

    // Edge output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_parent <= NPST_EIDX_W'(EXT_W'(i_e_parent));
            r_out_child  <= NPST_EIDX_W'(EXT_W'(i_e_child));
            r_out_last   <= i_e_last;
        end
    end

    assign o_sts.pipe_busy = r_s1_valid | r_s2_valid | r_s3_valid | r_s4_valid | r_s5_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_min_idx       = r_min_idx;
    assign o_min_parent    = r_min_par;
    assign o_out_valid     = r_out_valid;
    assign o_parent_index  = r_out_parent;
    assign o_child_index   = r_out_child;
    assign o_last_edge     = r_out_last;

endmodule

[rtl/npst_ctrl.sv]
// ============================================================================
// npst_ctrl: load and tree build sequencer
// Counts loaded positions, then per edge reads the source position, sweeps
// candidates, drains the pipeline and emits; scan order mode chains instead.
// ============================================================================
module npst_ctrl import npst_pkg::*; #(
    parameter  int MAX_SCANS = NPST_MAX_SCANS,
    localparam int IDX_W     = $clog2(MAX_SCANS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  logic             i_use_scan_order,
    input  t_sts             i_sts,
    input  logic [IDX_W-1:0] i_min_idx,
    input  logic [IDX_W-1:0] i_min_parent,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_rd_addr,
    output logic [IDX_W-1:0] o_wr_addr,
    output logic [IDX_W-1:0] o_src_idx,
    output logic [IDX_W-1:0] o_e_parent,
    output logic [IDX_W-1:0] o_e_child,
    output logic             o_e_last
);

    localparam int CNT_W = $clog2(MAX_SCANS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC_RD,
        ST_SRC_CAP,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT,
        ST_CHAIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_step, n_step;
    logic [IDX_W-1:0] r_y, n_y;
    logic [IDX_W-1:0] r_v, n_v;
    logic [IDX_W-1:0] r_i, n_i;
    logic             r_first, n_first;

    logic             w_room;
    logic [CNT_W-1:0] w_cnt_next;
    logic [CNT_W-1:0] w_n_m1;

    assign w_room     = r_count < CNT_W'(MAX_SCANS);
    assign w_cnt_next = r_count + CNT_W'(w_room);
    assign w_n_m1     = r_n - CNT_W'(1);

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_step     = r_step;
        n_y        = r_y;
        n_v        = r_v;
        n_i        = r_i;
        n_first    = r_first;
        o_cmd      = '0;
        o_cmd.first_sweep = r_first;
        o_in_ready = 1'b0;
        o_rd_addr  = r_y;
        o_e_parent = i_min_parent;
        o_e_child  = i_min_idx;
        o_e_last   = CNT_W'(r_step) == w_n_m1;

        case (r_state)
            // Take positions; the item marked last closes the set.
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.pos_we = w_room;
                    n_count      = w_cnt_next;
                    if (i_in_last) begin
                        n_count = '0;
                        n_n     = w_cnt_next;
                        n_step  = IDX_W'(1);
                        n_i     = IDX_W'(1);
                        if (w_cnt_next < CNT_W'(2)) begin
                            n_state = ST_IDLE;
                        end else if (i_use_scan_order) begin
                            n_state = ST_CHAIN;
                        end else begin
                            o_cmd.build_init = 1'b1;
                            n_v     = '0;
                            n_first = 1'b1;
                            n_state = ST_SRC_RD;
                        end
                    end
                end
            end
            // Read the position the next sweep relaxes from.
            ST_SRC_RD: begin
                o_rd_addr = r_v;
                n_state   = ST_SRC_CAP;
            end
            ST_SRC_CAP: begin
                o_cmd.src_cap     = 1'b1;
                o_cmd.sweep_start = 1'b1;
                n_y     = '0;
                n_state = ST_SWEEP;
            end
            // One candidate per cycle over all loaded positions.
            ST_SWEEP: begin
                o_cmd.sweep_valid = 1'b1;
                if (CNT_W'(r_y) == w_n_m1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_y = r_y + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_EMIT;
                end
            end
            // Attach the nearest candidate and send its edge.
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.attach = 1'b1;
                    n_first      = 1'b0;
                    if (CNT_W'(r_step) == w_n_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_step  = r_step + IDX_W'(1);
                        n_v     = i_min_idx;
                        n_state = ST_SRC_RD;
                    end
                end
            end
            // Chain edges in load order.
            ST_CHAIN: begin
                o_e_parent = r_i - IDX_W'(1);
                o_e_child  = r_i;
                o_e_last   = CNT_W'(r_i) == w_n_m1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (CNT_W'(r_i) == w_n_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_n     <= '0;
            r_step  <= '0;
            r_y     <= '0;
            r_v     <= '0;
            r_i     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_step  <= n_step;
            r_y     <= n_y;
            r_v     <= n_v;
            r_i     <= n_i;
            r_first <= n_first;
        end
    end

    assign o_wr_addr = r_count[IDX_W-1:0];
    assign o_src_idx = r_v;

endmodule

[rtl/nearest_position_spanning_tree.sv]
// ============================================================================
// nearest_position_spanning_tree: top level
// Loads a set of 3D positions and emits the edges of the spanning tree that
// grows from position zero by attaching the nearest outside position.
//
//   Channel   Direction  Handshake            Payload
//   i_pos     in         valid / ready        pos_x, pos_y, pos_z, last
//   o_edge    out        valid / ready        parent_index, child_index, last_edge
//   APB       in         psel/penable/pready  use_scan_order at address 0
//
// Positions are taken while the sequencer is idle. The item marked last
// starts the build, during which no position is taken. Each tree edge takes
// a source position read and capture, a sweep of one candidate per cycle
// through the position and best distance memories, a drain through the
// distance and relax pipeline, and the emission. Chain edges need no sweep.
// A stalled edge output holds the sequencer in its emit or chain state.
// Reset is synchronous; no clearing pass is needed.
// ============================================================================
module nearest_position_spanning_tree import npst_pkg::*; #(
    parameter int MAX_SCANS  = NPST_MAX_SCANS,
    parameter int COORD_BITS = NPST_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    npst_in_if.sink               i_pos,
    npst_out_if.source            o_edge,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_SCANS);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [IDX_W-1:0] w_rd_addr, w_wr_addr, w_src_idx;
    logic [IDX_W-1:0] w_e_parent, w_e_child;
    logic             w_e_last;
    logic [IDX_W-1:0] w_min_idx, w_min_parent;
    logic             r_use_scan_order;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_scan_order <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == ADDR_USE_SCAN_ORDER)) begin
            r_use_scan_order <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_USE_SCAN_ORDER) ? CFG_DATA_W'(r_use_scan_order) : '0;

    // Sequencer.
    npst_ctrl #(
        .MAX_SCANS (MAX_SCANS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_pos.valid),
        .i_in_last        (i_pos.last),
        .o_in_ready       (i_pos.ready),
        .i_use_scan_order (r_use_scan_order),
        .i_sts            (w_sts),
        .i_min_idx        (w_min_idx),
        .i_min_parent     (w_min_parent),
        .o_cmd            (w_cmd),
        .o_rd_addr        (w_rd_addr),
        .o_wr_addr        (w_wr_addr),
        .o_src_idx        (w_src_idx),
        .o_e_parent       (w_e_parent),
        .o_e_child        (w_e_child),
        .o_e_last         (w_e_last)
    );

    // Storage, distance pipeline and edge register.
    npst_datapath #(
        .MAX_SCANS  (MAX_SCANS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_rd_addr      (w_rd_addr),
        .i_wr_addr      (w_wr_addr),
        .i_src_idx      (w_src_idx),
        .i_pos_x        (i_pos.pos_x),
        .i_pos_y        (i_pos.pos_y),
        .i_pos_z        (i_pos.pos_z),
        .i_e_parent     (w_e_parent),
        .i_e_child      (w_e_child),
        .i_e_last       (w_e_last),
        .o_min_idx      (w_min_idx),
        .o_min_parent   (w_min_parent),
        .o_out_valid    (o_edge.valid),
        .i_out_ready    (o_edge.ready),
        .o_parent_index (o_edge.parent_index),
        .o_child_index  (o_edge.child_index),
        .o_last_edge    (o_edge.last_edge)
    );

endmodule
